FILE: sv/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg: shared types and constants of the color contrast checker
// Payload structs, luminance weights, offsets and divider sizing.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned RGB_W   = 3 * CHAN_W;
  localparam int unsigned RATIO_W = 8;

  // luminance 2126 R + 7152 G + 722 B, at most 2550000
  localparam int unsigned LUM_W = 22;
  localparam logic [LUM_W-1:0] WEIGHT_R = LUM_W'(2126);
  localparam logic [LUM_W-1:0] WEIGHT_G = LUM_W'(7152);
  localparam logic [LUM_W-1:0] WEIGHT_B = LUM_W'(722);

  // flare offset (0.05 on this scale) and the offset luminance of white
  localparam logic [LUM_W-1:0] LUM_OFFSET    = LUM_W'(127500);
  localparam logic [LUM_W-1:0] WHITE_LUM_OFS = LUM_W'(2677500);

  localparam logic [RGB_W-1:0]   WHITE_RGB       = RGB_W'(24'hFFFFFF);
  localparam logic [RGB_W-1:0]   BLACK_RGB       = RGB_W'(24'h000000);
  localparam logic [RATIO_W-1:0] MIN_RATIO_RESET = RATIO_W'(45);
  localparam logic [RATIO_W-1:0] RATIO_FLOOR     = RATIO_W'(10);
  localparam logic [RATIO_W-1:0] RATIO_CEIL      = RATIO_W'(210);

  // divider: numerator 20*hi + lo < 2^26, divisor 2*lo < 2^23
  localparam int unsigned NUM_W          = 26;
  localparam int unsigned DEN_W          = LUM_W + 1;
  localparam int unsigned Q_W            = RATIO_W;
  localparam int unsigned Q_IDX_W        = $clog2(Q_W);
  localparam int unsigned REM_W          = DEN_W + Q_W;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = Q_W / BITS_PER_STAGE;

  // registers from input to divider input: luminance stage, setup stage
  localparam int unsigned PRE_STAGES = 2;
  localparam int unsigned PIPE_DEPTH = PRE_STAGES + DIV_STAGES;

  typedef struct packed {
    logic [RGB_W-1:0] fore_color;
    logic [RGB_W-1:0] back_color;
  } ccc_in_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_tenths;
    logic               passes;
    logic [RGB_W-1:0]   adjusted_fore;
  } ccc_out_t;

  function automatic logic [LUM_W-1:0] luminance(input logic [RGB_W-1:0] rgb);
    logic [LUM_W-1:0] r;
    logic [LUM_W-1:0] g;
    logic [LUM_W-1:0] b;
    r = LUM_W'(rgb[3*CHAN_W-1:2*CHAN_W]);
    g = LUM_W'(rgb[2*CHAN_W-1:CHAN_W]);
    b = LUM_W'(rgb[CHAN_W-1:0]);
    return (WEIGHT_R * r) + (WEIGHT_G * g) + (WEIGHT_B * b);
  endfunction

endpackage

FILE: sv/color_contrast_checker.sv
// ----------------------------------------------------------------------------
// color_contrast_checker: contrast ratio check of a color pair
// Rates a foreground against a background and swaps in white or black
// when the pair falls short of the configured minimum ratio.
// ----------------------------------------------------------------------------
// Accepts one foreground/background pair per clock while the output is not
// stalled and returns one result per pair, in order, through these registers:
// one luminance stage, one stage that orders the luminances and sets up three
// divisions (the pair itself, white on the background, black on the
// background), four divider stages resolving two quotient bits each, and the
// output register. A stall on the output freezes the whole pipeline, so the
// input stalls in the same cycle. The minimum ratio (tenths, reset 45) is
// written through the always-ready configuration channel; the user must
// write it only while no pair is in flight, and the block does not enforce it.
// ----------------------------------------------------------------------------
module color_contrast_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  ccc_pkg::ccc_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output ccc_pkg::ccc_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ccc_pkg::RATIO_W-1:0]     cfg_data_i
);
  import ccc_pkg::*;

  logic en;

  logic [RATIO_W-1:0] min_ratio_q;

  logic             valid_q [PIPE_DEPTH];
  logic [RGB_W-1:0] fore_q  [PIPE_DEPTH];

  logic [LUM_W-1:0] lum_fore, lum_back;

  logic [LUM_W-1:0] hi_ofs, lo_ofs, back_ofs;
  logic [NUM_W-1:0] num_pair_d, num_white_d, num_black_d;
  logic [DEN_W-1:0] den_pair_d, den_white_d;
  logic [NUM_W-1:0] num_pair_q, num_white_q, num_black_q;
  logic [DEN_W-1:0] den_pair_q, den_white_q;

  logic [Q_W-1:0] ratio_pair, ratio_white, ratio_black;

  ccc_out_t out_d, out_q;
  logic     out_valid_q;

  // advance everything unless a held result is stalled
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // minimum ratio register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ratio_q <= MIN_RATIO_RESET;
    end else if (cfg_valid_i) begin
      min_ratio_q <= cfg_data_i;
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < PIPE_DEPTH; i++) begin
        valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int unsigned i = 1; i < PIPE_DEPTH; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      out_valid_q <= valid_q[PIPE_DEPTH-1];
    end
  end

  // carry the original foreground to the output stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      fore_q[0] <= in_data_i.fore_color;
      for (int unsigned i = 1; i < PIPE_DEPTH; i++) begin
        fore_q[i] <= fore_q[i-1];
      end
    end
  end

  ccc_luma u_luma (
    .clk_i      (clk_i),
    .en_i       (en),
    .pair_i     (in_data_i),
    .lum_fore_o (lum_fore),
    .lum_back_o (lum_back)
  );

  // order the luminances and form numerators and divisors
  always_comb begin
    hi_ofs      = ((lum_fore > lum_back) ? lum_fore : lum_back) + LUM_OFFSET;
    lo_ofs      = ((lum_fore > lum_back) ? lum_back : lum_fore) + LUM_OFFSET;
    back_ofs    = lum_back + LUM_OFFSET;
    num_pair_d  = (NUM_W'(hi_ofs) << 4) + (NUM_W'(hi_ofs) << 2) + NUM_W'(lo_ofs);
    den_pair_d  = DEN_W'(lo_ofs) << 1;
    num_white_d = (NUM_W'(WHITE_LUM_OFS) << 4) + (NUM_W'(WHITE_LUM_OFS) << 2)
                  + NUM_W'(back_ofs);
    den_white_d = DEN_W'(back_ofs) << 1;
    num_black_d = (NUM_W'(back_ofs) << 4) + (NUM_W'(back_ofs) << 2)
                  + NUM_W'(LUM_OFFSET);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_pair_q  <= num_pair_d;
      den_pair_q  <= den_pair_d;
      num_white_q <= num_white_d;
      den_white_q <= den_white_d;
      num_black_q <= num_black_d;
    end
  end

  ccc_div u_div_pair (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_pair_q),
    .den_i (den_pair_q),
    .quo_o (ratio_pair)
  );

  ccc_div u_div_white (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_white_q),
    .den_i (den_white_q),
    .quo_o (ratio_white)
  );

  // black sits at the offset alone, so its divisor is fixed
  ccc_div u_div_black (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_black_q),
    .den_i (DEN_W'(LUM_OFFSET) << 1),
    .quo_o (ratio_black)
  );

  // judge the pair and pick the replacement foreground; ties go to white
  always_comb begin
    out_d.ratio_tenths = ratio_pair;
    out_d.passes       = (ratio_pair >= min_ratio_q);
    if (out_d.passes) begin
      out_d.adjusted_fore = fore_q[PIPE_DEPTH-1];
    end else if (ratio_white >= ratio_black) begin
      out_d.adjusted_fore = WHITE_RGB;
    end else begin
      out_d.adjusted_fore = BLACK_RGB;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a delivered ratio lies between 1.0:1 and 21.0:1
  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.ratio_tenths >= RATIO_FLOOR &&
                     out_data_o.ratio_tenths <= RATIO_CEIL))
    else $error("ratio out of range");

  // pass flag agrees with the configured minimum
  a_pass_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.passes == (out_data_o.ratio_tenths >= min_ratio_q)))
    else $error("pass flag disagrees with minimum ratio");

  // a failing pair always gets white or black
  a_replacement: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.passes) |->
      (out_data_o.adjusted_fore == WHITE_RGB || out_data_o.adjusted_fore == BLACK_RGB))
    else $error("failing pair not replaced by white or black");

  // a stalled result freezes the input side in the same cycle
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(fore_q[0]) || !$past(in_valid_i)))
    else $error("pipeline advanced under output stall");

endmodule

FILE: sv/ccc_luma.sv
// ----------------------------------------------------------------------------
// ccc_luma: luminance stage
// Weights both colors of a pair and registers the two luminances.
// ----------------------------------------------------------------------------
module ccc_luma (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  ccc_pkg::ccc_in_t              pair_i,
  output logic [ccc_pkg::LUM_W-1:0]     lum_fore_o,
  output logic [ccc_pkg::LUM_W-1:0]     lum_back_o
);
  import ccc_pkg::*;

  logic [LUM_W-1:0] lum_fore_d, lum_fore_q;
  logic [LUM_W-1:0] lum_back_d, lum_back_q;

  // weight the channels of each color
  always_comb begin
    lum_fore_d = luminance(pair_i.fore_color);
    lum_back_d = luminance(pair_i.back_color);
  end

  // hold while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lum_fore_q <= lum_fore_d;
      lum_back_q <= lum_back_d;
    end
  end

  assign lum_fore_o = lum_fore_q;
  assign lum_back_o = lum_back_q;

endmodule

FILE: sv/ccc_div.sv
// ----------------------------------------------------------------------------
// ccc_div: pipelined restoring divider
// Produces an 8-bit quotient, two quotient bits per register stage.
// The caller guarantees num_i < 256 * den_i.
// ----------------------------------------------------------------------------
module ccc_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [ccc_pkg::NUM_W-1:0]     num_i,
  input  logic [ccc_pkg::DEN_W-1:0]     den_i,
  output logic [ccc_pkg::Q_W-1:0]       quo_o
);
  import ccc_pkg::*;

  logic [NUM_W-1:0] rem_q [DIV_STAGES-1];
  logic [DEN_W-1:0] den_q [DIV_STAGES-1];
  logic [Q_W-1:0]   quo_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [NUM_W-1:0] rem_in, rem_d;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in, quo_d;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // resolve this stage's quotient bits, most significant first
    always_comb begin
      logic [REM_W-1:0] trial;
      int unsigned      k;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int unsigned b = 0; b < BITS_PER_STAGE; b++) begin
        k     = Q_W - 1 - s * BITS_PER_STAGE - b;
        trial = REM_W'(den_in) << k;
        if (REM_W'(rem_d) >= trial) begin
          rem_d                 = rem_d - NUM_W'(trial);
          quo_d[k[Q_IDX_W-1:0]] = 1'b1;
        end
      end
    end

    // advance quotient, and remainder with divisor where a later stage needs them
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_d;
      end
    end

    if (s < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[DIV_STAGES-1];

endmodule
